@@ rtl/stc_pkg.sv @@
package stc_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned PROD_W   = SCALE_W + SAMPLE_W;

  localparam logic [PROD_W-1:0]   ROUND_ADD = PROD_W'(8'h7f);
  localparam logic [SAMPLE_W-1:0] SAT_MAX   = 8'hfe;
  localparam logic [SAMPLE_W-1:0] END_MARK  = 8'hff;
  localparam logic [SAMPLE_W-1:0] LOW_FLOOR = 8'h01;

  localparam logic [SCALE_W-1:0]  SCALE_RESET = 16'h0100;
  localparam logic [SAMPLE_W-1:0] LEVEL_RESET = 8'h80;
  localparam logic [SAMPLE_W-1:0] HYST_RESET  = 8'h00;
  localparam int unsigned         LEN_RESET   = 800;
  localparam int unsigned         LEN_FIELD_W = 13;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    TRIG_FREE = 2'd0,
    TRIG_RISE = 2'd1,
    TRIG_FALL = 2'd2
  } trig_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE = 3'd0,
    REG_MODE  = 3'd1,
    REG_LEVEL = 3'd2,
    REG_HYST  = 3'd3,
    REG_LEN   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [SCALE_W-1:0]  scale;
    logic [1:0]          mode;
    logic [SAMPLE_W-1:0] level;
    logic [SAMPLE_W-1:0] hyst;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] data;
    logic                eot;
  } res_t;

endpackage

@@ rtl/stc_queue.sv @@
module stc_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  // depth must be a power of two so the pointers wrap on their own; the block does not check it
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/stc_front.sv @@
module stc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [stc_pkg::SAMPLE_W-1:0]  sample,
  input  logic [stc_pkg::SCALE_W-1:0]   scale,
  output logic                          full,
  output logic                          q_push,
  output logic [stc_pkg::SAMPLE_W-1:0]  q_data,
  input  logic                          q_full
);

  logic [stc_pkg::PROD_W-1:0]   prod;
  logic [stc_pkg::SCALE_W-1:0]  shifted;
  logic [stc_pkg::SAMPLE_W-1:0] scaled;
  logic                         vld_r, vld_nxt;
  logic [stc_pkg::SAMPLE_W-1:0] val_r;
  logic                         ready;

  // full-width product, round, then saturate
  always_comb begin
    prod    = stc_pkg::PROD_W'(scale) * stc_pkg::PROD_W'(sample) + stc_pkg::ROUND_ADD;
    shifted = prod[stc_pkg::PROD_W-1:8];
    if (shifted > stc_pkg::SCALE_W'(stc_pkg::SAT_MAX)) begin
      scaled = stc_pkg::SAT_MAX;
    end else begin
      scaled = shifted[stc_pkg::SAMPLE_W-1:0];
    end
  end

  assign q_push = vld_r && !q_full;
  assign ready  = !vld_r || !q_full;
  assign full   = !ready;
  assign q_data = val_r;

  always_comb begin
    vld_nxt = vld_r;
    if (ready) begin
      vld_nxt = push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && push) begin
      val_r <= scaled;
    end
  end

endmodule

@@ rtl/stc_back.sv @@
module stc_back #(
  parameter int unsigned COUNT_BITS = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  stc_pkg::cfg_t                 cfg,
  input  logic [COUNT_BITS-1:0]         trace_len,
  input  logic                          rearm,
  input  logic                          in_empty,
  input  logic [stc_pkg::SAMPLE_W-1:0]  in_data,
  output logic                          in_pop,
  input  logic                          out_full,
  output logic                          out_push,
  output stc_pkg::res_t                 out_data
);

  logic                         armed_r, armed_nxt;
  logic [COUNT_BITS-1:0]        count_r, count_nxt;
  logic                         cmp_r, cmp_nxt;
  logic                         prev_r, prev_nxt;
  logic [stc_pkg::SAMPLE_W:0]   hi_sum;
  logic [stc_pkg::SAMPLE_W-1:0] hi_th, lo_th;
  logic                         fire;
  logic [COUNT_BITS-1:0]        cnt_inc;

  // thresholds, 9-bit sum; the clamp compares level with 255 minus hysteresis
  always_comb begin
    hi_sum = {1'b0, cfg.level} + {1'b0, cfg.hyst};
    if ({1'b0, cfg.level} < ({1'b0, stc_pkg::END_MARK} - {1'b0, cfg.hyst})) begin
      hi_th = hi_sum[stc_pkg::SAMPLE_W-1:0];
    end else begin
      hi_th = stc_pkg::END_MARK;
    end
    if (cfg.level > cfg.hyst) begin
      lo_th = cfg.level - cfg.hyst;
    end else begin
      lo_th = stc_pkg::LOW_FLOOR;
    end
  end

  assign in_pop = !in_empty && !out_full;

  always_comb begin
    if (in_data < lo_th) begin
      cmp_nxt = 1'b0;
    end else if (in_data >= hi_th) begin
      cmp_nxt = 1'b1;
    end else begin
      cmp_nxt = cmp_r;
    end
  end

  always_comb begin
    unique case (cfg.mode)
      stc_pkg::TRIG_RISE: fire = !prev_r && cmp_nxt;
      stc_pkg::TRIG_FALL: fire = prev_r && !cmp_nxt;
      default:            fire = 1'b1;
    endcase
  end

  always_comb begin
    armed_nxt     = armed_r;
    count_nxt     = count_r;
    prev_nxt      = prev_r;
    out_push      = 1'b0;
    out_data.data = in_data;
    out_data.eot  = 1'b0;
    cnt_inc       = (armed_r ? '0 : count_r) + 1'b1;
    if (in_pop) begin
      if (armed_r && !fire) begin
        prev_nxt = cmp_nxt;
      end else begin
        out_push = 1'b1;
        if (cnt_inc >= trace_len) begin
          out_data.data = stc_pkg::END_MARK;
          out_data.eot  = 1'b1;
          prev_nxt      = cmp_nxt;
          armed_nxt     = 1'b1;
          count_nxt     = '0;
        end else begin
          armed_nxt = 1'b0;
          count_nxt = cnt_inc;
        end
      end
    end
    if (rearm) begin
      armed_nxt = 1'b1;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b1;
      count_r <= '0;
      cmp_r   <= 1'b0;
      prev_r  <= 1'b0;
    end else begin
      armed_r <= armed_nxt;
      count_r <= count_nxt;
      prev_r  <= prev_nxt;
      if (in_pop) begin
        cmp_r <= cmp_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_push_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> in_pop)
    else $error("result pushed without a queued item");

  a_marker_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (out_push && out_data.eot) |=> armed_r)
    else $error("end marker did not re-arm");

  a_armed_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> (count_r == '0))
    else $error("count not clear while armed");

  a_marker_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_push && !out_data.eot) |-> (out_data.data != stc_pkg::END_MARK))
    else $error("scaled item collides with end marker");
`endif

endmodule

@@ rtl/scope_trigger_capture.sv @@
// channel   ports                                        handshake
// input     in_adc_sample                                push / full
// result    out_byte, out_eot                            empty / pop
// config    cfg_we, cfg_idx, cfg_data                    cfg_we, no wait
//
// one item per clock sustained while the result side keeps popping; an accepted
// sample loads the front register, then moves into the mid queue, and the back
// then writes the result queue, whereupon empty drops
// rst_n is synchronous: gain 1, free run, level 128, no hysteresis, length 800
// a stalled result side fills the result queue, then the mid queue, then the
// front register, and only then raises full
module scope_trigger_capture #(
  parameter int unsigned COUNT_BITS  = 13,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [stc_pkg::SAMPLE_W-1:0]    in_adc_sample,
  output logic                            empty,
  input  logic                            pop,
  output logic [stc_pkg::SAMPLE_W-1:0]    out_byte,
  output logic                            out_eot,
  input  logic                            cfg_we,
  input  logic [stc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [stc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  stc_pkg::cfg_t         cfg_r, cfg_nxt;
  logic [COUNT_BITS-1:0] len_r, len_nxt;
  logic                  rearm;

  // front to back queue
  logic                         mq_push, mq_full, mq_pop, mq_empty;
  logic [stc_pkg::SAMPLE_W-1:0] mq_wdata, mq_rdata;

  // back to result queue
  logic          rq_push, rq_full;
  stc_pkg::res_t rq_wdata, rq_rdata;

  // register decode; unknown indexes fall through untouched
  always_comb begin
    cfg_nxt = cfg_r;
    len_nxt = len_r;
    rearm   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_idx)
        stc_pkg::REG_SCALE: cfg_nxt.scale = cfg_data;
        stc_pkg::REG_MODE:  cfg_nxt.mode  = cfg_data[1:0];
        stc_pkg::REG_LEVEL: cfg_nxt.level = cfg_data[stc_pkg::SAMPLE_W-1:0];
        stc_pkg::REG_HYST:  cfg_nxt.hyst  = cfg_data[stc_pkg::SAMPLE_W-1:0];
        stc_pkg::REG_LEN: begin
          // length field is 13 bits, then kept to the counter width
          len_nxt = COUNT_BITS'(cfg_data[stc_pkg::LEN_FIELD_W-1:0]);
          rearm   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale <= stc_pkg::SCALE_RESET;
      cfg_r.mode  <= stc_pkg::TRIG_FREE;
      cfg_r.level <= stc_pkg::LEVEL_RESET;
      cfg_r.hyst  <= stc_pkg::HYST_RESET;
      len_r       <= COUNT_BITS'(stc_pkg::LEN_RESET);
    end else begin
      cfg_r <= cfg_nxt;
      len_r <= len_nxt;
    end
  end

  // front: accept and scale
  stc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .sample (in_adc_sample),
    .scale  (cfg_r.scale),
    .full   (full),
    .q_push (mq_push),
    .q_data (mq_wdata),
    .q_full (mq_full)
  );

  // decouples scaling from trigger tracking
  stc_queue #(
    .W     (stc_pkg::SAMPLE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (mq_wdata),
    .full  (mq_full),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty)
  );

  // back: comparator, trigger and capture count
  stc_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .trace_len (len_r),
    .rearm     (rearm),
    .in_empty  (mq_empty),
    .in_data   (mq_rdata),
    .in_pop    (mq_pop),
    .out_full  (rq_full),
    .out_push  (rq_push),
    .out_data  (rq_wdata)
  );

  // result queue, head drives the result ports
  stc_queue #(
    .W     ($bits(stc_pkg::res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (pop),
    .rdata (rq_rdata),
    .empty (empty)
  );

  assign out_byte = rq_rdata.data;
  assign out_eot  = rq_rdata.eot;

endmodule
